FILE: hw/rtl/sliding_window_average_macros.svh
// Assertion macros shared by the sliding window average RTL.
// Included by the top level; relies on clk and rst_n being in scope.
`ifndef SLIDING_WINDOW_AVERAGE_MACROS_SVH
`define SLIDING_WINDOW_AVERAGE_MACROS_SVH

// Condition that must hold at every clock edge outside reset.
`define SWA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define SWA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/swa_pkg.sv
// Package for the sliding window average: field widths and divider request type.
// No dependencies.
`timescale 1ns / 1ps

package swa_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int SUM_W      = 24;
    localparam int WLEN_W     = 8;
    localparam int QUO_W      = 16;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);
    localparam int MIN_WINDOW = 2;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 8'd8;

    typedef struct packed {
        logic                 start;
        logic [SUM_W-1:0]     dividend;
        logic [WLEN_W-1:0]    divisor;
    } div_req_t;

endpackage

FILE: hw/rtl/swa_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module swa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hw/rtl/swa_div.sv
// Bit-serial restoring divider producing one quotient bit per cycle.
// Depends on swa_pkg; expects the dividend's upper byte to be below the divisor.
`timescale 1ns / 1ps

module swa_div
    import swa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  div_req_t         req,
    output logic             done,
    output logic [QUO_W-1:0] quotient
);

    logic [WLEN_W-1:0]    rem_reg, rem_next;
    logic [QUO_W-1:0]     q_reg, q_next;
    logic [WLEN_W-1:0]    d_reg;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [WLEN_W:0]      trial;
    logic [WLEN_W:0]      diff;
    logic                 fits;

    assign trial = {rem_reg, q_reg[QUO_W-1]};
    assign diff  = trial - {1'b0, d_reg};
    assign fits  = (trial >= {1'b0, d_reg});

    always_comb
    begin
        rem_next  = rem_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend[SUM_W-1:QUO_W];
            q_next    = req.dividend[QUO_W-1:0];
            cnt_next  = DIV_CNT_W'(QUO_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[WLEN_W-1:0] : trial[WLEN_W-1:0];
            q_next   = {q_reg[QUO_W-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (req.start)
        begin
            d_reg <= req.divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

FILE: hw/rtl/sliding_window_average.sv
// Sliding window average: floor of the mean of the last N samples, N from a register.
// From request to result: bypass goes to the done state, priming runs the fill state,
// other requests run update and the 16-step serial divider. One request is in flight.
// Reset (asynchronous, active low) sets N to 8, clears the sum and ring position and
// arms priming; the history RAM is not cleared, priming fills it with the first sample.
// Depends on swa_pkg, swa_ram, swa_div and sliding_window_average_macros.svh.
`timescale 1ns / 1ps
`include "sliding_window_average_macros.svh"

module sliding_window_average
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                window_length_valid,
    output logic                window_length_ready,
    input  logic [WLEN_W-1:0]   window_length,
    input  logic                sample_valid,
    output logic                sample_stall,
    input  logic [SAMPLE_W-1:0] sample,
    output logic                average_valid,
    input  logic                average_stall,
    output logic [SAMPLE_W-1:0] average
);

    localparam int AW = $clog2(MAX_WINDOW);
    localparam logic [WLEN_W:0] MAXW = (WLEN_W + 1)'(MAX_WINDOW);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_FILL = 3'd1;
    localparam logic [2:0] S_UPD  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg, state_next;
    logic [WLEN_W-1:0]   wlen_reg, wlen_next;
    logic                primed_reg, primed_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic [SAMPLE_W-1:0] x_reg;
    logic [SAMPLE_W-1:0] res_reg, res_next;
    logic [SAMPLE_W-1:0] avg_reg;

    logic [WLEN_W-1:0]   n_eff;
    logic                bypass;
    logic                sample_accept;
    logic                out_load;
    logic [WLEN_W:0]     pos_inc;
    logic [AW-1:0]       pos_adv;
    logic [SUM_W-1:0]    sum_upd;
    logic                ram_wr_en;
    logic [AW-1:0]       ram_wr_addr;
    logic                ram_rd_en;
    logic [SAMPLE_W-1:0] ram_rd_data;
    div_req_t            div_req;
    logic                div_done;
    logic [QUO_W-1:0]    div_quotient;

    assign n_eff  = ({1'b0, wlen_reg} > MAXW) ? MAXW[WLEN_W-1:0] : wlen_reg;
    assign bypass = (n_eff < WLEN_W'(MIN_WINDOW));

    assign sample_stall        = (state_reg != S_IDLE);
    assign window_length_ready = (state_reg == S_IDLE);
    assign sample_accept       = sample_valid && !sample_stall;

    assign pos_inc = (WLEN_W + 1)'(pos_reg) + 1'b1;
    assign pos_adv = (pos_inc == {1'b0, n_eff}) ? '0 : pos_inc[AW-1:0];
    assign sum_upd = sum_reg - SUM_W'(ram_rd_data) + SUM_W'(x_reg);

    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || !average_stall);
    assign ram_wr_en   = (state_reg == S_FILL) || (state_reg == S_UPD);
    assign ram_wr_addr = (state_reg == S_FILL) ? cnt_reg : pos_reg;
    assign ram_rd_en   = sample_accept;

    assign div_req.start    = (state_reg == S_UPD);
    assign div_req.dividend = sum_upd;
    assign div_req.divisor  = n_eff;

    swa_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (x_reg),
        .rd_en   (ram_rd_en),
        .rd_addr (pos_adv),
        .rd_data (ram_rd_data)
    );

    swa_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_quotient)
    );

    always_comb
    begin
        state_next     = state_reg;
        wlen_next      = wlen_reg;
        primed_next    = primed_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        cnt_next       = cnt_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !average_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (window_length_valid)
                begin
                    wlen_next   = window_length;
                    primed_next = 1'b0;
                end
                if (sample_accept)
                begin
                    priority if (bypass)
                    begin
                        res_next   = sample;
                        state_next = S_DONE;
                    end
                    else if (!primed_reg)
                    begin
                        sum_next   = '0;
                        cnt_next   = '0;
                        state_next = S_FILL;
                    end
                    else
                    begin
                        pos_next   = pos_adv;
                        state_next = S_UPD;
                    end
                end
            end
            S_FILL:
            begin
                sum_next = sum_reg + SUM_W'(x_reg);
                if ((WLEN_W + 1)'(cnt_reg) + 1'b1 == {1'b0, n_eff})
                begin
                    res_next    = x_reg;
                    primed_next = 1'b1;
                    pos_next    = '0;
                    state_next  = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            S_UPD:
            begin
                sum_next   = sum_upd;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quotient;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= WLEN_RESET;
            primed_reg    <= 1'b0;
            sum_reg       <= '0;
            pos_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wlen_reg      <= wlen_next;
            primed_reg    <= primed_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            x_reg <= sample;
        end
        res_reg <= res_next;
        if (out_load)
        begin
            avg_reg <= res_reg;
        end
    end

    assign average_valid = out_valid_reg;
    assign average       = avg_reg;

    `SWA_ASSERT_ALWAYS(a_div_done_in_div, !div_done || state_reg == S_DIV,
        "divider finished outside the divide state")
    `SWA_ASSERT_NEXT(a_bypass_result, sample_accept && bypass,
        state_reg == S_DONE && res_reg == $past(sample), "bypass result is not the sample")
    `SWA_ASSERT_NEXT(a_primed_update, sample_accept && !bypass && primed_reg,
        state_reg == S_UPD && pos_reg == $past(pos_adv), "primed request did not advance ring")
    `SWA_ASSERT_ALWAYS(a_pos_in_window,
        !(primed_reg && state_reg == S_IDLE) || (WLEN_W + 1)'(pos_reg) < (WLEN_W + 1)'(n_eff),
        "ring position outside the window")

endmodule
